[src/rotating_phasor_chain_macros.svh]
// ----------------------------------------------------------------------------
// Rotating phasor chain assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef ROTATING_PHASOR_CHAIN_MACROS_SVH
`define ROTATING_PHASOR_CHAIN_MACROS_SVH

// same-cycle implication, disabled during reset
`define RPC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rotating phasor chain port check failed");

// next-cycle implication, disabled during reset
`define RPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rotating phasor chain port check failed");

`endif

[src/rpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating phasor chain package
// Types, constants and fixed-point helpers shared by the chain and its ROM.
// ----------------------------------------------------------------------------
package rpc_pkg;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 56;
   localparam int COORD_W    = 22;
   localparam int INDEX_W    = 6;
   localparam int PROD_W     = 42;
   localparam int DELTA_W    = 18;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 22'sd2097151;
   localparam logic signed [COORD_W-1:0] COORD_MIN = -22'sd2097152;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_MUL_RATE,
      ST_PHASE,
      ST_SIN,
      ST_COS,
      ST_ACC_X,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_RATE,
      MUL_SIN,
      MUL_COS
   } mul_sel_type;

   typedef struct packed {
      logic        load_wr;
      logic        rd_en;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        phase_wr;
      logic        acc_y_en;
      logic        acc_x_en;
   } ctl_type;

   // Q14 sine of table entry k for a table of 2^bits entries per turn
   function automatic logic signed [15:0] sine_entry(input int k, input int bits);
      int a;
      int q;
      int x;
      int z;
      int z2;
      int t;
      int v;
      int s;
      a  = (k << (16 - bits)) & 32'h0000_FFFF;
      q  = (a >> 14) & 3;
      x  = a & 32'h0000_3FFF;
      z  = ((q & 1) != 0) ? (16384 - x) : x;
      z2 = (z * z) >> 14;
      t  = (1160 * z2) >> 14;
      v  = ((10512 - t) * z2) >> 14;
      s  = ((25736 - v) * z) >> 14;
      if ((q & 2) != 0) begin
         s = -s;
      end
      return 16'(s);
   endfunction

   // Q.18 product to Q.4, ties toward plus infinity
   function automatic logic signed [DELTA_W-1:0] round_q4(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      r = (p + 42'sd8192) >>> 14;
      return r[DELTA_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_add(
      input logic signed [COORD_W-1:0] a,
      input logic signed [DELTA_W-1:0] d
   );
      logic signed [COORD_W+1:0] s;
      s = (COORD_W+2)'(a) + (COORD_W+2)'(d);
      if (s > (COORD_W+2)'(COORD_MAX)) begin
         return COORD_MAX;
      end
      if (s < (COORD_W+2)'(COORD_MIN)) begin
         return COORD_MIN;
      end
      return s[COORD_W-1:0];
   endfunction

endpackage

[src/rpc_sine_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating phasor chain sine ROM
// Full-turn Q14 sine table with a registered read port.
// ----------------------------------------------------------------------------
module rpc_sine_rom #(
   parameter int ADDR_W = 10
) (
   input  logic                     clock,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic signed [15:0]       rd_data
);
   import rpc_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic signed [15:0] rom_table [DEPTH];
   logic signed [15:0] rd_data_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_entry
      assign rom_table[k] = sine_entry(k, ADDR_W);
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom_table[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rotating_phasor_chain.sv]
`timescale 1ns / 1ps
// Append: the entry is loaded and its tip formed by the tick steps, then back to idle.
// Tick over N phasors, for each phasor: read, one shared multiplier used three
// times, ROM read for sine and cosine, accumulate, hand off.
// Ready only while idle; a tick with no phasors stays idle and gives no response.
// Synchronous reset clears the count, the tail tip and the handshake; the
// coefficient stores are not cleared.
// ----------------------------------------------------------------------------
// Rotating phasor chain
// Table of rotating phasors walked by a sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
module rotating_phasor_chain #(
   parameter int MAX_HARMONICS   = 32,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // magnitude[15:0], angular_rate[39:16], start_phase[55:40], time_step[71:56]
   input  logic [rpc_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[0]
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // phasor_index[5:0], tip_x[27:6], tip_y[49:28], zero[55:50]
   output logic [rpc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   // status[0]
   output logic                           rsp_tuser
);
   import rpc_pkg::*;

   localparam int IDX_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
   localparam int CNT_W = $clog2(MAX_HARMONICS + 1);
   localparam int QTR   = 1 << (SINE_TABLE_BITS - 2);

   state_type state_ff, state_in;
   ctl_type   ctl;

   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] cur_ff;
   logic             op_ff;
   logic [15:0]      dt_ff;
   logic signed [15:0] req_mag_ff;
   logic signed [23:0] req_rate_ff;
   logic [15:0]      req_start_ff;

   logic signed [15:0] mag_mem   [MAX_HARMONICS];
   logic signed [23:0] rate_mem  [MAX_HARMONICS];
   logic [31:0]        phase_mem [MAX_HARMONICS];
   logic signed [15:0] mag_rd_ff;
   logic signed [23:0] rate_rd_ff;
   logic [31:0]        phase_rd_ff;
   logic               phase_we;
   logic [31:0]        phase_wdata;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [24:0]       mul_a;
   logic signed [16:0]       mul_b;
   logic [31:0]              phase_new;
   logic [31:0]              phase_ff;

   logic [SINE_TABLE_BITS-1:0] rom_addr;
   logic signed [15:0]         rom_data;

   logic signed [COORD_W-1:0] acc_x_ff, acc_y_ff, acc_x_in, acc_y_in;
   logic signed [COORD_W-1:0] tail_x_ff, tail_y_ff;

   logic                      rsp_valid_ff;
   logic [IDX_W-1:0]          rsp_index_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                      rsp_last_ff;
   logic                      rsp_status_ff;

   logic req_fire, rsp_fire, table_full, table_empty, chain_end;

   assign req_fire    = req_tvalid && req_tready;
   assign rsp_fire    = rsp_valid_ff && rsp_tready;
   assign table_full  = (count_ff == CNT_W'(MAX_HARMONICS));
   assign table_empty = (count_ff == '0);
   assign chain_end   = ((CNT_W'(cur_ff) + CNT_W'(1)) == count_ff);

   rpc_sine_rom #(
      .ADDR_W (SINE_TABLE_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_TICK) begin
                  state_in = table_empty ? ST_IDLE : ST_READ;
               end else begin
                  state_in = table_full ? ST_OUT : ST_LOAD;
               end
            end
         end
         ST_LOAD:     state_in = ST_READ;
         ST_READ:     state_in = ST_MUL_RATE;
         ST_MUL_RATE: state_in = ST_PHASE;
         ST_PHASE:    state_in = ST_SIN;
         ST_SIN:      state_in = ST_COS;
         ST_COS:      state_in = ST_ACC_X;
         ST_ACC_X:    state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_fire) begin
               state_in = rsp_last_ff ? ST_IDLE : ST_READ;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // per-state controls
   always_comb begin
      ctl         = '0;
      ctl.mul_sel = MUL_RATE;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE:     req_tready = 1'b1;
         ST_LOAD:     ctl.load_wr = 1'b1;
         ST_READ:     ctl.rd_en = 1'b1;
         ST_MUL_RATE: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MUL_RATE;
         end
         ST_PHASE:    ctl.phase_wr = 1'b1;
         ST_SIN: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MUL_SIN;
         end
         ST_COS: begin
            ctl.mul_en   = 1'b1;
            ctl.mul_sel  = MUL_COS;
            ctl.acc_y_en = 1'b1;
         end
         ST_ACC_X:    ctl.acc_x_en = 1'b1;
         default:     ctl = '0;
      endcase
   end

   // shared multiplier operands
   always_comb begin
      case (ctl.mul_sel)
         MUL_RATE: begin
            mul_a = 25'(rate_rd_ff);
            mul_b = signed'({1'b0, dt_ff});
         end
         MUL_SIN: begin
            mul_a = 25'(mag_rd_ff);
            mul_b = -17'(rom_data);
         end
         MUL_COS: begin
            mul_a = 25'(mag_rd_ff);
            mul_b = 17'(rom_data);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign phase_new   = phase_rd_ff + prod_ff[31:0];
   assign phase_we    = ctl.load_wr || ctl.phase_wr;
   assign phase_wdata = ctl.load_wr ? {req_start_ff, 16'h0000} : phase_new;
   assign rom_addr    = ctl.phase_wr ? phase_new[31 -: SINE_TABLE_BITS]
                      : phase_ff[31 -: SINE_TABLE_BITS] + SINE_TABLE_BITS'(QTR);
   assign acc_y_in    = sat_add(acc_y_ff, round_q4(prod_ff));
   assign acc_x_in    = sat_add(acc_x_ff, round_q4(prod_ff));

   // coefficient stores
   always_ff @(posedge clock) begin
      if (ctl.load_wr) begin
         mag_mem[cur_ff]  <= req_mag_ff;
         rate_mem[cur_ff] <= req_rate_ff;
      end
      if (phase_we) begin
         phase_mem[cur_ff] <= phase_wdata;
      end
      if (ctl.rd_en) begin
         mag_rd_ff   <= mag_mem[cur_ff];
         rate_rd_ff  <= rate_mem[cur_ff];
         phase_rd_ff <= phase_mem[cur_ff];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff        <= req_tuser;
         req_mag_ff   <= req_tdata[15:0];
         req_rate_ff  <= req_tdata[39:16];
         req_start_ff <= req_tdata[55:40];
         // append reuses the tick path with zero elapsed time
         dt_ff        <= (req_tuser == OP_TICK) ? req_tdata[71:56] : 16'h0000;
         cur_ff       <= (req_tuser == OP_TICK) ? '0 : count_ff[IDX_W-1:0];
         acc_x_ff     <= (req_tuser == OP_TICK) ? '0 : tail_x_ff;
         acc_y_ff     <= (req_tuser == OP_TICK) ? '0 : tail_y_ff;
         rsp_index_ff  <= '0;
         rsp_x_ff      <= tail_x_ff;
         rsp_y_ff      <= tail_y_ff;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= 1'b1;
      end
      if (ctl.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (ctl.phase_wr) begin
         phase_ff <= phase_new;
      end
      if (ctl.acc_y_en) begin
         acc_y_ff <= acc_y_in;
      end
      if (ctl.acc_x_en) begin
         acc_x_ff      <= acc_x_in;
         rsp_index_ff  <= cur_ff;
         rsp_x_ff      <= acc_x_in;
         rsp_y_ff      <= acc_y_ff;
         rsp_last_ff   <= (op_ff == OP_APPEND) || chain_end;
         rsp_status_ff <= 1'b0;
      end
      if (rsp_fire && !rsp_last_ff) begin
         cur_ff <= cur_ff + IDX_W'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tail_x_ff    <= '0;
         tail_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end else if (ctl.acc_x_en ||
                      (req_fire && req_tuser == OP_APPEND && table_full)) begin
            rsp_valid_ff <= 1'b1;
         end
         // commit the tail tip, and for an append the new entry, once the final tip is taken
         if (rsp_fire && rsp_last_ff && !rsp_status_ff) begin
            tail_x_ff <= rsp_x_ff;
            tail_y_ff <= rsp_y_ff;
            if (op_ff == OP_APPEND) begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2*COORD_W - INDEX_W){1'b0}},
                        rsp_y_ff, rsp_x_ff, INDEX_W'(rsp_index_ff)};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

[src/rpc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating phasor chain port checker
// Watches the request and response channels of the chain over time.
// ----------------------------------------------------------------------------
`include "rotating_phasor_chain_macros.svh"

module rpc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rpc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           rsp_tuser
);
   import rpc_pkg::*;

   logic append_fire;
   logic full_status;

   assign append_fire = req_tvalid && req_tready && (req_tuser == OP_APPEND);
   assign full_status = rsp_tvalid && rsp_tuser;

   // hold a stalled response
   `RPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // busy after an append request is taken; an empty tick may stay ready
   `RPC_ASSERT_NEXT(a_busy_after_append, clock, reset, append_fire, !req_tready)
   // never ready while a response is pending
   `RPC_ASSERT_NOW(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   // a rejected append is a single marked response at index zero
   `RPC_ASSERT_NOW(a_full_shape, clock, reset, full_status,
                   rsp_tlast && (rsp_tdata[INDEX_W-1:0] == '0))

endmodule

bind rotating_phasor_chain rpc_checker u_rpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
